FILE: rtl/lpgm_pkg.sv
// Shared constants, types and the sine/cosine series function for the lidar point grid marker.
`timescale 1ns / 1ps
package lpgm_pkg;
   localparam int GridColsDefault = 256;
   localparam int GridRowsDefault = 256;
   localparam int TrigFracDefault = 15;

   typedef enum logic [2:0] {
      REG_NEAR_MIN   = 3'd0,
      REG_NEAR_MAX   = 3'd1,
      REG_FAR_MIN    = 3'd2,
      REG_FAR_MAX    = 3'd3,
      REG_CELL_SIZE  = 3'd4,
      REG_ORIGIN_COL = 3'd5,
      REG_ORIGIN_ROW = 3'd6,
      REG_START_HDG  = 3'd7
   } reg_index_type;

   localparam logic OP_MARK = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [13:0] distance_mm;
      logic [15:0] scan_angle_cdeg;
      logic signed [15:0] heading_cdeg;
      logic signed [15:0] robot_x_mm;
      logic signed [15:0] robot_y_mm;
      logic [7:0]  read_col;
      logic [7:0]  read_row;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_col;
      logic [7:0] cell_row;
      logic       marked;
      logic       gated_out;
      logic       off_grid;
      logic       cell_value;
   } rsp_type;

   typedef struct packed {
      logic [3:0] csr_index;
      logic [15:0] csr_data;
   } csr_type;

   // Series sine/cosine of r in [0,4500] cdeg, rounded to frac bits; evaluated once per
   // table entry at elaboration, never on a signal path.
   function automatic logic [63:0] trig_pair(input int r, input int frac);
      logic [63:0] x, x2, ts, tc;
      longint ss, cc, s, c;
      begin
         x  = 64'(r) * 64'd187403;
         x2 = (x * x) >> 30;
         ts = x;
         tc = 64'd1 << 30;
         ss = longint'(x);
         cc = longint'(64'd1 << 30);
         for (int k = 1; k <= 5; k++) begin
            ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k & 1) != 0) begin
               ss = ss - longint'(ts);
               cc = cc - longint'(tc);
            end else begin
               ss = ss + longint'(ts);
               cc = cc + longint'(tc);
            end
         end
         if (ss < 0) ss = 0;
         if (cc < 0) cc = 0;
         s = (ss + (longint'(1) << (29 - frac))) >>> (30 - frac);
         c = (cc + (longint'(1) << (29 - frac))) >>> (30 - frac);
         trig_pair = {s[31:0], c[31:0]};
      end
   endfunction
endpackage

FILE: rtl/lpgm_if.sv
// Valid/ready channel interfaces for request, response and register writes.
`timescale 1ns / 1ps
interface lpgm_req_if;
   import lpgm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lpgm_rsp_if;
   import lpgm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lpgm_csr_if;
   import lpgm_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lidar_point_grid_marker.sv
// Lidar point grid marker: distance gate, direction and trig, division, grid mark or read.
// The pipe holds nine stages plus one divider stage per numerator bit (35 bits by default);
// it takes one item per cycle while the response side is not stalled and no grid clear runs.
// The whole pipe advances only when its last stage is empty or being taken.
// Reset: synchronous, active high; clears registers to their defaults and then sweeps the
// grid memory one row per cycle, over all GRID_ROWS rows, with requests held off.
`timescale 1ns / 1ps
module lidar_point_grid_marker #(
   parameter int GRID_COLS      = lpgm_pkg::GridColsDefault,
   parameter int GRID_ROWS      = lpgm_pkg::GridRowsDefault,
   parameter int TRIG_FRAC_BITS = lpgm_pkg::TrigFracDefault
) (
   input  logic  clock,
   input  logic  reset,
   lpgm_req_if.sink   req,
   lpgm_rsp_if.source rsp,
   lpgm_csr_if.sink   csr
);
   import lpgm_pkg::*;

   localparam int F     = TRIG_FRAC_BITS;
   localparam int ColW  = $clog2(GRID_COLS);
   localparam int RowW  = $clog2(GRID_ROWS);
   localparam int TrigW = F + 2;
   localparam int NumW  = 16 + F + 4;
   localparam int DenW  = 10 + F;
   localparam int DivLat = NumW + 1;
   localparam int OffW  = NumW + 2;

   // constant sine/cosine table over [0,4500]
   localparam int TabN = 4501;
   logic signed [TrigW-1:0] sin_tab [TabN];
   logic signed [TrigW-1:0] cos_tab [TabN];
   for (genvar t = 0; t < TabN; t++) begin : g_tab
      localparam logic [63:0] P = trig_pair(t, F);
      assign sin_tab[t] = TrigW'(P[63:32]);
      assign cos_tab[t] = TrigW'(P[31:0]);
   end

   // ---------------- registers ----------------
   logic [13:0] near_min_ff, near_max_ff, far_min_ff, far_max_ff;
   logic [9:0]  cell_size_ff;
   logic [7:0]  origin_col_ff, origin_row_ff;
   logic signed [15:0] start_hdg_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         near_min_ff   <= 14'd150;
         near_max_ff   <= 14'd650;
         far_min_ff    <= 14'd700;
         far_max_ff    <= 14'd2700;
         cell_size_ff  <= 10'd50;
         origin_col_ff <= 8'd128;
         origin_row_ff <= 8'd128;
         start_hdg_ff  <= '0;
      end else if (csr.valid && csr.data.csr_index[3] == 1'b0) begin
         case (reg_index_type'(csr.data.csr_index[2:0]))
            REG_NEAR_MIN:   near_min_ff   <= csr.data.csr_data[13:0];
            REG_NEAR_MAX:   near_max_ff   <= csr.data.csr_data[13:0];
            REG_FAR_MIN:    far_min_ff    <= csr.data.csr_data[13:0];
            REG_FAR_MAX:    far_max_ff    <= csr.data.csr_data[13:0];
            REG_CELL_SIZE:  cell_size_ff  <= csr.data.csr_data[9:0];
            REG_ORIGIN_COL: origin_col_ff <= csr.data.csr_data[7:0];
            REG_ORIGIN_ROW: origin_row_ff <= csr.data.csr_data[7:0];
            REG_START_HDG:  start_hdg_ff  <= csr.data.csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- clearing sweep ----------------
   logic [RowW:0] clr_ff, clr_in;
   logic clearing;
   assign clearing = !clr_ff[RowW];
   assign clr_in   = clearing ? clr_ff + 1'b1 : clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else       clr_ff <= clr_in;
   end

   // ---------------- pipeline control ----------------
   logic out_valid_ff, advance;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance && !clearing;

   // per-item control carried alongside the divider
   typedef struct packed {
      logic       valid;
      logic       opcode;
      logic       gated;
      logic [7:0] read_col;
      logic [7:0] read_row;
   } ctl_type;

   // pass control on, dropping the valid bit under reset
   function automatic ctl_type pass_ctl(input ctl_type c, input logic clr);
      pass_ctl = c;
      if (clr) pass_ctl.valid = 1'b0;
   endfunction

   // stage 1: gate, direction mod 36000
   ctl_type s1_ff;
   logic [15:0] s1_a_ff;
   logic [13:0] s1_d_ff;
   logic signed [15:0] s1_rx_ff, s1_ry_ff;
   logic [9:0] s1_cs_ff;

   logic signed [19:0] dir;
   logic signed [19:0] a0;
   logic [15:0] a_mod;
   logic ok;
   always_comb begin
      dir = 20'(req.data.heading_cdeg) - 20'(start_hdg_ff)
          - 20'(signed'({1'b0, req.data.scan_angle_cdeg}));
      // dir in [-131070, 65535]: lift by four turns, then strip four, two and one turn
      a0 = dir + 20'sd144000;
      if (a0 >= 20'sd144000) a0 = a0 - 20'sd144000;
      if (a0 >= 20'sd72000) a0 = a0 - 20'sd72000;
      if (a0 >= 20'sd36000) a0 = a0 - 20'sd36000;
      a_mod = a0[15:0];
      ok = (req.data.distance_mm > near_min_ff && req.data.distance_mm < near_max_ff)
         || (req.data.distance_mm > far_min_ff && req.data.distance_mm < far_max_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff.valid <= 1'b0;
      else if (advance) s1_ff.valid <= req.valid && req.ready;
      if (advance) begin
         s1_ff.opcode   <= req.data.opcode;
         s1_ff.gated    <= !ok;
         s1_ff.read_col <= req.data.read_col;
         s1_ff.read_row <= req.data.read_row;
         s1_a_ff  <= a_mod;
         s1_d_ff  <= req.data.distance_mm;
         s1_rx_ff <= req.data.robot_x_mm;
         s1_ry_ff <= req.data.robot_y_mm;
         s1_cs_ff <= (cell_size_ff == '0) ? 10'd1 : cell_size_ff;
      end
   end

   // stage 2: quadrant and fold
   ctl_type s2_ff;
   logic [1:0]  s2_q_ff;
   logic [12:0] s2_r_ff;
   logic        s2_swap_ff;
   logic [13:0] s2_d_ff;
   logic signed [15:0] s2_rx_ff, s2_ry_ff;
   logic [9:0] s2_cs_ff;
   logic [1:0]  q_in;
   logic [15:0] r_in;
   always_comb begin
      if (s1_a_ff >= 16'd27000) begin q_in = 2'd3; r_in = s1_a_ff - 16'd27000; end
      else if (s1_a_ff >= 16'd18000) begin q_in = 2'd2; r_in = s1_a_ff - 16'd18000; end
      else if (s1_a_ff >= 16'd9000) begin q_in = 2'd1; r_in = s1_a_ff - 16'd9000; end
      else begin q_in = 2'd0; r_in = s1_a_ff; end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= pass_ctl(s1_ff, reset);
         s2_q_ff    <= q_in;
         s2_swap_ff <= r_in > 16'd4500;
         s2_r_ff    <= (r_in > 16'd4500) ? 13'(16'd9000 - r_in) : r_in[12:0];
         s2_d_ff  <= s1_d_ff;
         s2_rx_ff <= s1_rx_ff;
         s2_ry_ff <= s1_ry_ff;
         s2_cs_ff <= s1_cs_ff;
      end else if (reset) s2_ff.valid <= 1'b0;
   end

   // stage 3: table lookup and quadrant signs
   ctl_type s3_ff;
   logic signed [TrigW-1:0] s3_s_ff, s3_c_ff;
   logic [13:0] s3_d_ff;
   logic signed [15:0] s3_rx_ff, s3_ry_ff;
   logic [9:0] s3_cs_ff;
   logic signed [TrigW-1:0] ts, tc, bs, bc, sv, cv;
   always_comb begin
      ts = sin_tab[s2_r_ff];
      tc = cos_tab[s2_r_ff];
      bs = s2_swap_ff ? tc : ts;
      bc = s2_swap_ff ? ts : tc;
      case (s2_q_ff)
         2'd0: begin cv = bc;  sv = bs;  end
         2'd1: begin cv = -bs; sv = bc;  end
         2'd2: begin cv = -bc; sv = -bs; end
         default: begin cv = bs; sv = -bc; end
      endcase
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff <= pass_ctl(s2_ff, reset);
         s3_s_ff  <= sv;
         s3_c_ff  <= cv;
         s3_d_ff  <= s2_d_ff;
         s3_rx_ff <= s2_rx_ff;
         s3_ry_ff <= s2_ry_ff;
         s3_cs_ff <= s2_cs_ff;
      end else if (reset) s3_ff.valid <= 1'b0;
   end

   // stage 4: products
   ctl_type s4_ff;
   logic signed [NumW-1:0] s4_px_ff, s4_py_ff;
   logic signed [NumW-1:0] s4_bx_ff, s4_by_ff;
   logic [DenW-1:0] s4_den_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ff <= pass_ctl(s3_ff, reset);
         s4_px_ff  <= NumW'(signed'({1'b0, s3_d_ff}) * s3_c_ff);
         s4_py_ff  <= NumW'(signed'({1'b0, s3_d_ff}) * s3_s_ff);
         s4_bx_ff  <= NumW'(s3_rx_ff) <<< F;
         s4_by_ff  <= NumW'(s3_ry_ff) <<< F;
         s4_den_ff <= DenW'(s3_cs_ff) << F;
      end else if (reset) s4_ff.valid <= 1'b0;
   end

   // stage 5: numerators
   ctl_type s5_ff;
   logic signed [NumW-1:0] s5_nx_ff, s5_ny_ff;
   logic [DenW-1:0] s5_den_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s5_ff <= pass_ctl(s4_ff, reset);
         s5_nx_ff  <= s4_px_ff + s4_bx_ff;
         s5_ny_ff  <= s4_py_ff + s4_by_ff;
         s5_den_ff <= s4_den_ff;
      end else if (reset) s5_ff.valid <= 1'b0;
   end

   // divider stages
   logic signed [NumW-1:0] qx, qy;
   lpgm_divider #(.NumW(NumW), .DenW(DenW)) u_div_x (
      .clock(clock), .advance(advance), .num(s5_nx_ff), .den(s5_den_ff), .quo(qx));
   lpgm_divider #(.NumW(NumW), .DenW(DenW)) u_div_y (
      .clock(clock), .advance(advance), .num(s5_ny_ff), .den(s5_den_ff), .quo(qy));

   ctl_type dl_ff [DivLat];
   always_ff @(posedge clock) begin
      if (advance) begin
         dl_ff[0] <= pass_ctl(s5_ff, reset);
         for (int i = 1; i < DivLat; i++) begin
            dl_ff[i] <= pass_ctl(dl_ff[i-1], reset);
         end
      end else if (reset) begin
         for (int i = 0; i < DivLat; i++) dl_ff[i].valid <= 1'b0;
      end
   end
   ctl_type dv;
   assign dv = dl_ff[DivLat-1];

   // stage 6: origin add, bounds, memory address
   ctl_type s6_ff;
   logic s6_off_ff;
   logic [ColW-1:0] s6_col_ff;
   logic [RowW-1:0] s6_row_ff;
   logic signed [OffW-1:0] gx, gy;
   logic off_in;
   logic [ColW-1:0] col_in;
   logic [RowW-1:0] row_in;
   always_comb begin
      gx = OffW'(qx) + OffW'(signed'({1'b0, origin_col_ff}));
      gy = OffW'(qy) + OffW'(signed'({1'b0, origin_row_ff}));
      if (dv.opcode == OP_READ) begin
         off_in = (32'(dv.read_col) >= 32'(GRID_COLS)) || (32'(dv.read_row) >= 32'(GRID_ROWS));
         col_in = ColW'(dv.read_col);
         row_in = RowW'(dv.read_row);
      end else begin
         off_in = gx < 0 || gx >= OffW'(GRID_COLS) || gy < 0 || gy >= OffW'(GRID_ROWS);
         col_in = gx[ColW-1:0];
         row_in = gy[RowW-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s6_ff <= pass_ctl(dv, reset);
         s6_off_ff <= off_in;
         s6_col_ff <= col_in;
         s6_row_ff <= row_in;
      end else if (reset) s6_ff.valid <= 1'b0;
   end

   // grid memory: one row word per address; stage 7 reads, stage 8 writes back
   logic [GRID_COLS-1:0] grid_mem [GRID_ROWS];
   logic [GRID_COLS-1:0] rd_ff;
   ctl_type s7_ff;
   logic s7_off_ff;
   logic [ColW-1:0] s7_col_ff;
   logic [RowW-1:0] s7_row_ff;
   logic s7_mark;
   assign s7_mark = s7_ff.valid && s7_ff.opcode == OP_MARK && !s7_ff.gated && !s7_off_ff;

   // forward the row being written back when the next item hits the same row
   logic fwd_in, fwd_ff;
   logic [GRID_COLS-1:0] fwd_word_ff;
   logic [GRID_COLS-1:0] row_word;
   assign row_word = fwd_ff ? fwd_word_ff : rd_ff;

   logic [GRID_COLS-1:0] wr_word;
   always_comb begin
      wr_word = row_word;
      wr_word[s7_col_ff] = 1'b1;
   end
   assign fwd_in = s7_mark && s7_row_ff == s6_row_ff;

   always_ff @(posedge clock) begin
      if (clearing) begin
         grid_mem[clr_ff[RowW-1:0]] <= '0;
      end else if (advance && s7_mark) begin
         grid_mem[s7_row_ff] <= wr_word;
      end
      if (advance) begin
         rd_ff <= grid_mem[s6_row_ff];
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_ff <= pass_ctl(s6_ff, reset);
         s7_off_ff <= s6_off_ff;
         s7_col_ff <= s6_col_ff;
         s7_row_ff <= s6_row_ff;
         fwd_word_ff <= wr_word;
      end else if (reset) s7_ff.valid <= 1'b0;
   end

   // effective row word seen by stage 7
   logic [GRID_COLS-1:0] wr_base;
   always_comb wr_base = row_word;

   // stage 8: response register
   rsp_type out_ff, out_in;
   always_comb begin
      out_in = '0;
      if (s7_ff.opcode == OP_MARK && s7_ff.gated) begin
         out_in.gated_out = 1'b1;
      end else if (s7_off_ff) begin
         out_in.off_grid = 1'b1;
      end else begin
         out_in.cell_col = 8'(s7_col_ff);
         out_in.cell_row = 8'(s7_row_ff);
         if (s7_ff.opcode == OP_MARK) out_in.marked = 1'b1;
         else out_in.cell_value = wr_base[s7_col_ff];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= s7_ff.valid;
      if (advance) out_ff <= out_in;
   end
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   // ---------------- checks ----------------
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req.ready) else $error("request taken during grid clear");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response dropped under stall");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $countones({rsp.data.marked, rsp.data.gated_out, rsp.data.off_grid}) <= 1)
      else $error("conflicting result flags");
endmodule

FILE: rtl/lpgm_divider.sv
// Pipelined signed restoring divider: one quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps
module lpgm_divider #(
   parameter int NumW = 48,
   parameter int DenW = 30
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic signed [NumW-1:0]  num,
   input  logic        [DenW-1:0]  den,
   output logic signed [NumW-1:0]  quo
);
   localparam int RemW = DenW + 1;

   logic [NumW-1:0] q_ff  [NumW+1];
   logic [RemW-1:0] r_ff  [NumW+1];
   logic [DenW-1:0] d_ff  [NumW+1];
   logic            neg_ff[NumW+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff[0]   <= num[NumW-1] ? NumW'(-num) : NumW'(num);
         r_ff[0]   <= '0;
         d_ff[0]   <= den;
         neg_ff[0] <= num[NumW-1];
      end
   end

   for (genvar i = 0; i < NumW; i++) begin : g_step
      logic [RemW:0]   trial;
      logic [RemW-1:0] rem_in;
      logic [NumW-1:0] q_in;
      assign trial  = {r_ff[i], q_ff[i][NumW-1-i]} - {2'b00, d_ff[i]};
      assign rem_in = trial[RemW] ? RemW'({r_ff[i], q_ff[i][NumW-1-i]}) : trial[RemW-1:0];
      // replace the dividend bit just consumed by the quotient bit
      always_comb begin
         q_in = q_ff[i];
         q_in[NumW-1-i] = ~trial[RemW];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            r_ff[i+1]   <= rem_in;
            d_ff[i+1]   <= d_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            q_ff[i+1]   <= q_in;
         end
      end
   end

   assign quo = neg_ff[NumW] ? NumW'(-q_ff[NumW]) : NumW'(q_ff[NumW]);
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the lidar point grid marker: directed table, then random beats.
`timescale 1ns / 1ps
module tb;
   import lpgm_pkg::*;

   localparam int          Frac        = 15;
   localparam longint      FracOne     = 64'sd1 << Frac;
   localparam int          NumCols     = 256;
   localparam int          NumRows     = 256;
   localparam int          DrainCycles = 60;
   localparam int          StallLimit  = 6000;
   localparam int          LongHold    = 300;
   localparam logic [3:0]  RegUnused   = 4'd9;

   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpgm_req_if req_ch ();
   lpgm_rsp_if rsp_ch ();
   lpgm_csr_if csr_ch ();

   lidar_point_grid_marker dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #1 clock = ~clock;

   // Predictor state: register copies and the occupancy bits.
   logic [13:0]        near_lo, near_hi, far_lo, far_hi;
   logic [9:0]         cell_mm;
   logic [7:0]         org_col, org_row;
   logic signed [15:0] hdg_zero;
   bit                 occ_bits [NumCols*NumRows];
   rsp_type            cell_results_due [$];
   logic [15:0]        marked_cells [$];

   int unsigned fail_count, n_marked, n_gated, n_off, n_reads, n_items;
   int unsigned snd_idle, rcv_idle;
   bit          long_hold_req;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Sine and cosine of r in [0,4500] cdeg by series, Q30 then rounded to Frac bits.
   function automatic void series_sin_cos(input int unsigned r, output longint s,
                                          output longint c);
      bit [63:0] x, x2, ts, tc;
      longint    ss, cc;
      x  = 64'(r) * 64'd187403;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cc = longint'(tc);
      for (int k = 1; k <= 5; k++) begin
         ts = ((ts * x2) >> 30) / 64'((2*k) * (2*k + 1));
         tc = ((tc * x2) >> 30) / 64'((2*k - 1) * (2*k));
         if (k % 2 == 1) begin
            ss -= longint'(ts);
            cc -= longint'(tc);
         end else begin
            ss += longint'(ts);
            cc += longint'(tc);
         end
      end
      if (ss < 0) ss = 0;
      if (cc < 0) cc = 0;
      s = (ss + (64'sd1 << (29 - Frac))) >>> (30 - Frac);
      c = (cc + (64'sd1 << (29 - Frac))) >>> (30 - Frac);
   endfunction

   function automatic rsp_type grid_outcome(input req_type r);
      rsp_type o;
      longint  dirn, a, s, c, bs, bc, den, nx, ny, gx, gy;
      int unsigned q, rem;
      bit      in_win;
      o = '0;
      if (r.opcode == OP_READ) begin
         n_reads++;
         o.cell_col   = r.read_col;
         o.cell_row   = r.read_row;
         o.cell_value = occ_bits[int'(r.read_row)*NumCols + int'(r.read_col)];
         return o;
      end
      in_win = (r.distance_mm > near_lo && r.distance_mm < near_hi) ||
               (r.distance_mm > far_lo && r.distance_mm < far_hi);
      if (!in_win) begin
         n_gated++;
         o.gated_out = 1'b1;
         return o;
      end
      dirn = longint'(r.heading_cdeg) - longint'(hdg_zero) - longint'(r.scan_angle_cdeg);
      a = dirn % 36000;
      if (a < 0) a += 36000;
      q   = int'(a / 9000);
      rem = int'(a % 9000);
      if (rem <= 4500) series_sin_cos(rem, bs, bc);
      else series_sin_cos(9000 - rem, bc, bs);
      case (q)
         0: begin c = bc;  s = bs;  end
         1: begin c = -bs; s = bc;  end
         2: begin c = -bc; s = -bs; end
         default: begin c = bs; s = -bc; end
      endcase
      den = longint'(cell_mm == 0 ? 10'd1 : cell_mm) * FracOne;
      nx  = longint'(r.robot_x_mm) * FracOne + longint'(r.distance_mm) * c;
      ny  = longint'(r.robot_y_mm) * FracOne + longint'(r.distance_mm) * s;
      gx  = nx / den + longint'(org_col);
      gy  = ny / den + longint'(org_row);
      if (gx < 0 || gx >= NumCols || gy < 0 || gy >= NumRows) begin
         n_off++;
         o.off_grid = 1'b1;
         return o;
      end
      occ_bits[int'(gy)*NumCols + int'(gx)] = 1'b1;
      o.cell_col = gx[7:0];
      o.cell_row = gy[7:0];
      o.marked   = 1'b1;
      n_marked++;
      marked_cells.push_back({gx[7:0], gy[7:0]});
      if (marked_cells.size() > 64) void'(marked_cells.pop_front());
      return o;
   endfunction

   function automatic req_type mk_req(input logic op, input int d, input int scan, input int hdg,
                                      input int rx, input int ry, input int rc, input int rr);
      req_type r;
      r.opcode          = op;
      r.distance_mm     = d[13:0];
      r.scan_angle_cdeg = scan[15:0];
      r.heading_cdeg    = hdg[15:0];
      r.robot_x_mm      = rx[15:0];
      r.robot_y_mm      = ry[15:0];
      r.read_col        = rc[7:0];
      r.read_row        = rr[7:0];
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input int col, input int row, input int mk, input int gt,
                                      input int off, input int val);
      rsp_type o;
      o.cell_col   = col[7:0];
      o.cell_row   = row[7:0];
      o.marked     = mk[0];
      o.gated_out  = gt[0];
      o.off_grid   = off[0];
      o.cell_value = val[0];
      return o;
   endfunction

   task automatic send_beat(input req_type r, input bit known, input rsp_type e);
      rsp_type p;
      while ($urandom_range(99) < snd_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      p = grid_outcome(r);
      cell_results_due.push_back(known ? e : p);
      n_items++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (cell_results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [3:0] idx, input int val);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= '{csr_index: idx, csr_data: val[15:0]};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         4'(REG_NEAR_MIN):   near_lo  = val[13:0];
         4'(REG_NEAR_MAX):   near_hi  = val[13:0];
         4'(REG_FAR_MIN):    far_lo   = val[13:0];
         4'(REG_FAR_MAX):    far_hi   = val[13:0];
         4'(REG_CELL_SIZE):  cell_mm  = val[9:0];
         4'(REG_ORIGIN_COL): org_col  = val[7:0];
         4'(REG_ORIGIN_ROW): org_row  = val[7:0];
         4'(REG_START_HDG):  hdg_zero = val[15:0];
         default: ;
      endcase
   endtask

   task automatic write_setting(input int nlo, input int nhi, input int flo, input int fhi,
                                input int cs, input int oc, input int orw, input int sh);
      write_reg(4'(REG_NEAR_MIN), nlo);
      write_reg(4'(REG_NEAR_MAX), nhi);
      write_reg(4'(REG_FAR_MIN), flo);
      write_reg(4'(REG_FAR_MAX), fhi);
      write_reg(4'(REG_CELL_SIZE), cs);
      write_reg(4'(REG_ORIGIN_COL), oc);
      write_reg(4'(REG_ORIGIN_ROW), orw);
      write_reg(4'(REG_START_HDG), sh);
   endtask

   // One beat in four reads a cell; marks use mostly in-window distances near the grid, the rest full-range noise.
   function automatic req_type random_req();
      int    d, span, rx, ry, pick;
      logic [15:0] mc;
      if ($urandom_range(99) < 25) begin
         if (marked_cells.size() != 0 && $urandom_range(1) == 1) begin
            mc = marked_cells[$urandom_range(marked_cells.size() - 1)];
            return mk_req(OP_READ, $urandom_range(16383), 0, 0, 0, 0,
                          int'(mc[15:8]), int'(mc[7:0]));
         end
         return mk_req(OP_READ, $urandom_range(16383), $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(255), $urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 45 && near_hi > near_lo + 1)
         d = $urandom_range(int'(near_hi) - 1, int'(near_lo) + 1);
      else if (pick < 85 && far_hi > far_lo + 1)
         d = $urandom_range(int'(far_hi) - 1, int'(far_lo) + 1);
      else
         d = $urandom_range(16383);
      span = (cell_mm == 0 ? 1 : int'(cell_mm)) * 120;
      if (span > 32767) span = 32767;
      if ($urandom_range(99) < 80) begin
         rx = $urandom_range(2*span) - span;
         ry = $urandom_range(2*span) - span;
      end else begin
         rx = $urandom;
         ry = $urandom;
      end
      return mk_req(OP_MARK, d, $urandom_range(35999), $urandom_range(36000) - 18000,
                    rx, ry, $urandom, $urandom);
   endfunction

   // Receiver: random back-pressure plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cell_results_due.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = cell_results_due.pop_front();
            if (rsp_ch.data.cell_col != want.cell_col)
               report_mismatch("cell_col", int'(rsp_ch.data.cell_col), int'(want.cell_col));
            if (rsp_ch.data.cell_row != want.cell_row)
               report_mismatch("cell_row", int'(rsp_ch.data.cell_row), int'(want.cell_row));
            if (rsp_ch.data.marked != want.marked)
               report_mismatch("marked", int'(rsp_ch.data.marked), int'(want.marked));
            if (rsp_ch.data.gated_out != want.gated_out)
               report_mismatch("gated_out", int'(rsp_ch.data.gated_out),
                               int'(want.gated_out));
            if (rsp_ch.data.off_grid != want.off_grid)
               report_mismatch("off_grid", int'(rsp_ch.data.off_grid), int'(want.off_grid));
            if (rsp_ch.data.cell_value != want.cell_value)
               report_mismatch("cell_value", int'(rsp_ch.data.cell_value),
                               int'(want.cell_value));
         end
      end
   end

   // Watchdog: cycles with no beat on any channel.
   int unsigned quiet_cycles;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      dir_row_type rows [$];
      rsp_type     z;
      rsp_type     gated;
      z = '0;
      gated = mk_rsp(0, 0, 0, 1, 0, 0);
      near_lo = 14'd150; near_hi = 14'd650; far_lo = 14'd700; far_hi = 14'd2700;
      cell_mm = 10'd50; org_col = 8'd128; org_row = 8'd128; hdg_zero = '0;
      snd_idle = 0; rcv_idle = 0;

      rows.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
      rows.push_back('{mk_req(OP_READ, 16383, 0, 0, 0, 0, 255, 255), 1'b1,
                       mk_rsp(255, 255, 0, 0, 0, 0)});
      rows.push_back('{mk_req(OP_MARK, 0, 0, 0, 0, 0, 0, 0), 1'b1, gated});
      rows.push_back('{mk_req(OP_MARK, 150, 0, 0, 0, 0, 0, 0), 1'b1, gated});
      rows.push_back('{mk_req(OP_MARK, 650, 0, 0, 0, 0, 0, 0), 1'b1, gated});
      rows.push_back('{mk_req(OP_MARK, 700, 0, 0, 0, 0, 0, 0), 1'b1, gated});
      rows.push_back('{mk_req(OP_MARK, 2700, 0, 0, 0, 0, 0, 0), 1'b1, gated});
      rows.push_back('{mk_req(OP_MARK, 16383, 0, 0, 0, 0, 0, 0), 1'b1, gated});
      rows.push_back('{mk_req(OP_MARK, 500, 0, 0, 0, 0, 0, 0), 1'b1,
                       mk_rsp(138, 128, 1, 0, 0, 0)});
      rows.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0, 138, 128), 1'b1,
                       mk_rsp(138, 128, 0, 0, 0, 1)});
      rows.push_back('{mk_req(OP_MARK, 1000, 0, 0, -32768, 0, 0, 0), 1'b1,
                       mk_rsp(0, 0, 0, 0, 1, 0)});
      rows.push_back('{mk_req(OP_MARK, 1000, 0, 0, 32767, 0, 0, 0), 1'b1,
                       mk_rsp(0, 0, 0, 0, 1, 0)});
      rows.push_back('{mk_req(OP_MARK, 151, 35999, 18000, 0, 0, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 649, 9000, -18000, 100, -100, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 701, 4500, 0, 0, 0, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 2699, 27000, 0, 0, 0, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 2000, 13500, 1234, -3000, 2500, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 400, 31500, -4500, 0, 32767, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 1500, 22499, 17999, 1200, -1300, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 1500, 65535, -32768, 0, 0, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_MARK, 1500, 0, 32767, 0, 0, 0, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0, 255, 0), 1'b0, z});
      rows.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 255), 1'b0, z});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_beat(rows[i].r, rows[i].known, rows[i].e);
      drain_results();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_setting(150, 650, 700, 2700, 50, 128, 128, 0);
            1: write_setting(0, 16383, 0, 0, 1, 0, 0, -18000);
            2: write_setting(1000, 3000, 8000, 16383, 1023, 255, 255, 18000);
            3: begin
               write_setting(100, 5000, 5000, 16383, 0, 10, 250, -9000);
               write_reg(RegUnused, 16'hFFFF);
            end
            default: write_setting(150, 650, 700, 2700, 20, 128, 128, 4500);
         endcase
         snd_idle = (ph < 2) ? 9 : (ph < 4) ? 46 : 0;
         rcv_idle = (ph < 2) ? 46 : (ph < 4) ? 9 : 0;
         for (int n = 0; n < 180; n++) begin
            // hold the receiver off while beats keep coming in
            if (ph == 4 && n == 40) long_hold_req = 1'b1;
            send_beat(random_req(), 0, z);
         end
         drain_results();
      end

      $display("Covered %0d beats: %0d marked, %0d gated, %0d off grid, %0d reads,",
               n_items, n_marked, n_gated, n_off, n_reads);
      $display("over five register settings including window, cell size and origin extremes.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
